// ===== hw/rtl/pvbc_pkg.sv =====
`timescale 1ns / 1ps

package pvbc_pkg;

    localparam int PHASE_BITS_DEF = 16;
    localparam int ANG_BITS       = 24;

    // sin(pi/2 z) Taylor coefficients, Q30
    localparam logic [31:0] K1 = 32'd1686629713;
    localparam logic [31:0] K3 = 32'd693598668;
    localparam logic [31:0] K5 = 32'd85569306;
    localparam logic [31:0] K7 = 32'd5026995;
    localparam logic [31:0] K9 = 32'd172272;

    localparam logic [23:0] SUM_MAX  = 24'hFFFFFF;
    localparam logic [16:0] UNIT_Q16 = 17'd65536;
    localparam logic [17:0] COST_MAX = 18'd131072;

    localparam int ROOT_ITERS = 26;
    localparam int DIV_ITERS  = 25;

    // Horner coefficient for step 0..3
    function automatic logic [31:0] k_coef(input logic [1:0] h);
        logic [31:0] k;
        case (h)
            2'd0:    k = K7;
            2'd1:    k = K5;
            2'd2:    k = K3;
            default: k = K1;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/phase_vector_bilinear_cost.sv =====
`timescale 1ns / 1ps
// Takes one item at a time: s_axis_tready is high only in idle, so a new item is
// accepted only after the previous one is done; a last item adds a 25-step restoring divide.
// The work is paced by the single shared 34x34 multiplier (60 polynomial, 14
// blend/square products) and the 26-step square root. Synchronous active-low
// reset: sum 0, pattern count 1.
module phase_vector_bilinear_cost #(
    parameter int PHASE_BITS = pvbc_pkg::PHASE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [6:0]   i_cfg_data,     // pattern_count
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // match_phase, corner_a, corner_b, corner_c, corner_d, frac_x, frac_y (16 each)
    input  logic [111:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata    // mean_cost [17:0], zero pad
);
    import pvbc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_Z2    = 4'd1;
    localparam logic [3:0] ST_HORN  = 4'd2;
    localparam logic [3:0] ST_ZA    = 4'd3;
    localparam logic [3:0] ST_BLEND = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_ROOT  = 4'd6;
    localparam logic [3:0] ST_ACC   = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]          r_state;
    logic [3:0]          r_ev;
    logic [4:0]          r_step;
    logic                r_axis;
    logic [15:0]         r_ph [0:4];
    logic [15:0]         r_u, r_v;
    logic                r_last;
    logic signed [17:0]  r_vx [0:4];
    logic signed [17:0]  r_vy [0:4];
    logic [30:0]         r_z2;
    logic [31:0]         r_acc;
    logic [16:0]         r_qs;
    logic signed [33:0]  r_t, r_b;
    logic signed [51:0]  r_e;
    logic signed [26:0]  r_ex, r_ey;
    logic [51:0]         r_sq;
    logic [29:0]         r_rem;
    logic [25:0]         r_root;
    logic [23:0]         r_sum;
    logic [6:0]          r_cnt;
    logic [6:0]          r_div;
    logic [24:0]         r_num;
    logic [6:0]          r_drem;
    logic                r_out_valid;
    logic [17:0]         r_out;

    function automatic logic [23:0] phase_ang(input logic [15:0] raw);
        logic [23:0] w;
        w = 24'(raw) & ((24'd1 << PHASE_BITS) - 24'd1);
        return w << (ANG_BITS - PHASE_BITS);
    endfunction

    logic [23:0]         ang;
    logic [22:0]         zt;
    logic [30:0]         z;
    logic signed [33:0]  mul_a, mul_b;
    logic signed [67:0]  prod;
    logic signed [17:0]  corner_v, m_v;
    logic [32:0]         s_rnd;
    logic [18:0]         s_sh;
    logic [16:0]         q_val;
    logic signed [17:0]  ps, pc;
    logic signed [51:0]  e_diff;
    logic [29:0]         rem_n, trial;
    logic [26:0]         root_rnd;
    logic [24:0]         sum_add;
    logic [23:0]         sum_sat;
    logic [6:0]          div_n;
    logic [7:0]          drem_n;
    logic                in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {6'd0, r_out};

    always_comb begin
        ang = phase_ang(r_ph[r_ev[3:1]]);
        zt = r_ev[0] ? (23'h400000 - {1'b0, ang[21:0]}) : {1'b0, ang[21:0]};
        z = {zt, 8'd0};

        case (r_step[1:0])
            2'd0:    corner_v = r_axis ? r_vy[1] : r_vx[1];
            2'd1:    corner_v = r_axis ? r_vy[2] : r_vx[2];
            2'd2:    corner_v = r_axis ? r_vy[3] : r_vx[3];
            default: corner_v = r_axis ? r_vy[4] : r_vx[4];
        endcase
        m_v = r_axis ? r_vy[0] : r_vx[0];

        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_Z2: begin
                mul_a = {3'd0, z};
                mul_b = {3'd0, z};
            end
            ST_HORN: begin
                mul_a = {3'd0, r_z2};
                mul_b = {2'd0, r_acc};
            end
            ST_ZA: begin
                mul_a = {3'd0, z};
                mul_b = {2'd0, r_acc};
            end
            ST_BLEND: begin
                case (r_step[2:0])
                    3'd0, 3'd2: begin
                        mul_a = {16'd0, 18'(18'h10000 - {2'd0, r_u})};
                        mul_b = 34'(corner_v);
                    end
                    3'd1, 3'd3: begin
                        mul_a = {18'd0, r_u};
                        mul_b = 34'(corner_v);
                    end
                    3'd4: begin
                        mul_a = {16'd0, 18'(18'h10000 - {2'd0, r_v})};
                        mul_b = r_t;
                    end
                    3'd5: begin
                        mul_a = {18'd0, r_v};
                        mul_b = r_b;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            ST_SQ: begin
                mul_a = r_step[0] ? 34'(r_ey) : 34'(r_ex);
                mul_b = r_step[0] ? 34'(r_ey) : 34'(r_ex);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;

        s_rnd = {1'b0, prod[61:30]} + 33'd8192;
        s_sh = s_rnd[32:14];
        q_val = (s_sh > 19'(UNIT_Q16)) ? UNIT_Q16 : s_sh[16:0];
        ps = {1'b0, r_qs};
        pc = {1'b0, q_val};

        e_diff = r_e - (52'(m_v) <<< 32) + 52'sd8388608;

        rem_n = {r_rem[27:0], r_sq[51:50]};
        trial = {2'd0, r_root, 2'b01};

        root_rnd = 27'(r_root) + 27'd128;
        sum_add = 25'(r_sum) + 25'(root_rnd[26:8]);
        sum_sat = sum_add[24] ? SUM_MAX : sum_add[23:0];
        div_n = (r_cnt == 7'd0) ? 7'd1 : r_cnt;

        drem_n = {r_drem, r_num[24]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ev <= '0;
            r_step <= '0;
            r_axis <= 1'b0;
            r_sum <= '0;
            r_cnt <= 7'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cnt <= i_cfg_data;
            end
            if (r_state == ST_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_ph[0] <= s_axis_tdata[15:0];
                        r_ph[1] <= s_axis_tdata[31:16];
                        r_ph[2] <= s_axis_tdata[47:32];
                        r_ph[3] <= s_axis_tdata[63:48];
                        r_ph[4] <= s_axis_tdata[79:64];
                        r_u <= s_axis_tdata[95:80];
                        r_v <= s_axis_tdata[111:96];
                        r_last <= s_axis_tlast;
                        r_ev <= '0;
                        r_state <= ST_Z2;
                    end
                end
                ST_Z2: begin
                    r_z2 <= prod[60:30];
                    r_acc <= K9;
                    r_step <= '0;
                    r_state <= ST_HORN;
                end
                ST_HORN: begin
                    r_acc <= k_coef(r_step[1:0]) - prod[61:30];
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd3) begin
                        r_state <= ST_ZA;
                    end
                end
                ST_ZA: begin
                    if (!r_ev[0]) begin
                        r_qs <= q_val;
                        r_ev <= r_ev + 4'd1;
                        r_state <= ST_Z2;
                    end else begin
                        case (ang[23:22])
                            2'd0: begin
                                r_vx[r_ev[3:1]] <= pc;
                                r_vy[r_ev[3:1]] <= ps;
                            end
                            2'd1: begin
                                r_vx[r_ev[3:1]] <= -ps;
                                r_vy[r_ev[3:1]] <= pc;
                            end
                            2'd2: begin
                                r_vx[r_ev[3:1]] <= -pc;
                                r_vy[r_ev[3:1]] <= -ps;
                            end
                            default: begin
                                r_vx[r_ev[3:1]] <= ps;
                                r_vy[r_ev[3:1]] <= -pc;
                            end
                        endcase
                        if (r_ev == 4'd9) begin
                            r_step <= '0;
                            r_axis <= 1'b0;
                            r_state <= ST_BLEND;
                        end else begin
                            r_ev <= r_ev + 4'd1;
                            r_state <= ST_Z2;
                        end
                    end
                end
                ST_BLEND: begin
                    r_step <= r_step + 5'd1;
                    case (r_step[2:0])
                        3'd0: r_t <= prod[33:0];
                        3'd1: r_t <= r_t + prod[33:0];
                        3'd2: r_b <= prod[33:0];
                        3'd3: r_b <= r_b + prod[33:0];
                        3'd4: r_e <= prod[51:0];
                        3'd5: r_e <= r_e + prod[51:0];
                        default: begin
                            r_step <= '0;
                            if (!r_axis) begin
                                r_ex <= e_diff[50:24];
                                r_axis <= 1'b1;
                            end else begin
                                r_ey <= e_diff[50:24];
                                r_state <= ST_SQ;
                            end
                        end
                    endcase
                end
                ST_SQ: begin
                    if (!r_step[0]) begin
                        r_sq <= prod[51:0];
                        r_step <= 5'd1;
                    end else begin
                        r_sq <= r_sq + prod[51:0];
                        r_rem <= '0;
                        r_root <= '0;
                        r_step <= '0;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (rem_n >= trial) begin
                        r_rem <= rem_n - trial;
                        r_root <= {r_root[24:0], 1'b1};
                    end else begin
                        r_rem <= rem_n;
                        r_root <= {r_root[24:0], 1'b0};
                    end
                    r_sq <= {r_sq[49:0], 2'b00};
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(ROOT_ITERS - 1)) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (!r_last) begin
                        r_sum <= sum_sat;
                        r_state <= ST_IDLE;
                    end else begin
                        r_sum <= '0;
                        r_div <= div_n;
                        r_num <= 25'(sum_sat) + 25'(div_n[6:1]);
                        r_drem <= '0;
                        r_step <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (drem_n >= {1'b0, r_div}) begin
                        r_drem <= 7'(drem_n - {1'b0, r_div});
                        r_num <= {r_num[23:0], 1'b1};
                    end else begin
                        r_drem <= drem_n[6:0];
                        r_num <= {r_num[23:0], 1'b0};
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'(DIV_ITERS - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out <= (r_num > 25'(COST_MAX)) ? COST_MAX : r_num[17:0];
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== dv/tb_phase_vector_bilinear_cost.sv =====
`timescale 1ns / 1ps

module tb_phase_vector_bilinear_cost;

    typedef struct packed {
        logic [15:0] match_phase;
        logic [15:0] corner_a;
        logic [15:0] corner_b;
        logic [15:0] corner_c;
        logic [15:0] corner_d;
        logic [15:0] frac_x;
        logic [15:0] frac_y;
        logic        last;
    } pattern_t;

    localparam int PH_BITS   = 16;
    localparam int LIMIT_CYC = 3000000;
    localparam int DRAIN_CYC = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [6:0]   i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;

    phase_vector_bilinear_cost DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    pattern_t    pending_q[$];
    logic [17:0] cost_q[$];
    logic [6:0]  model_count;
    logic [23:0] model_sum = '0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          send_hold;

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("MISMATCH %s got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    function automatic longint poly_sine(input longint z22);
        longint z, z2, acc, s;
        z = z22 <<< 8;
        z2 = (z * z) >>> 30;
        acc = pvbc_pkg::K9;
        acc = longint'(pvbc_pkg::K7) - ((z2 * acc) >>> 30);
        acc = longint'(pvbc_pkg::K5) - ((z2 * acc) >>> 30);
        acc = longint'(pvbc_pkg::K3) - ((z2 * acc) >>> 30);
        acc = longint'(pvbc_pkg::K1) - ((z2 * acc) >>> 30);
        s = (z * acc) >>> 30;
        s = (s + 8192) >>> 14;
        if (s > 65536) s = 65536;
        return s;
    endfunction

    task automatic phase_to_vec(input logic [15:0] ph, output longint vx, output longint vy);
        logic [23:0] ang;
        longint t, s, c;
        ang = 24'(ph) << (24 - PH_BITS);
        t = ang[21:0];
        s = poly_sine(t);
        c = poly_sine(64'h400000 - t);
        case (ang[23:22])
            2'd0: begin vx = c;  vy = s;  end
            2'd1: begin vx = -s; vy = c;  end
            2'd2: begin vx = -c; vy = -s; end
            default: begin vx = s; vy = -c; end
        endcase
    endtask

    function automatic longint q24_round(input longint x);
        longint t;
        t = x + (longint'(1) <<< 50);
        t = (t + (longint'(1) <<< 23)) >>> 24;
        return t - (longint'(1) <<< 26);
    endfunction

    function automatic longint floor_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    task automatic predict_cost(input pattern_t p);
        longint mx, my, ax, ay, bx, by, cx, cy, dx, dy, u, v, nu, nv, ex, ey;
        longint unsigned sq, pat_dist, div, mean, acc;
        phase_to_vec(p.match_phase, mx, my);
        phase_to_vec(p.corner_a, ax, ay);
        phase_to_vec(p.corner_b, bx, by);
        phase_to_vec(p.corner_c, cx, cy);
        phase_to_vec(p.corner_d, dx, dy);
        u = p.frac_x;
        v = p.frac_y;
        nu = 65536 - u;
        nv = 65536 - v;
        ex = q24_round(nv * (nu * ax + u * bx) + v * (nu * cx + u * dx) - (mx <<< 32));
        ey = q24_round(nv * (nu * ay + u * by) + v * (nu * cy + u * dy) - (my <<< 32));
        sq = longint'(ex * ex) + longint'(ey * ey);
        pat_dist = (floor_sqrt(sq) + 128) >> 8;
        acc = model_sum + pat_dist;
        model_sum = (acc > 64'hFFFFFF) ? 24'hFFFFFF : acc[23:0];
        if (p.last) begin
            div = (model_count == 0) ? 1 : model_count;
            mean = (model_sum + div / 2) / div;
            if (mean > 131072) mean = 131072;
            cost_q.push_back(mean[17:0]);
            model_sum = 0;
        end
    endtask

    function automatic pattern_t rand_pattern(input int pct_last);
        pattern_t p;
        p.match_phase = 16'($urandom);
        p.corner_a = 16'($urandom);
        p.corner_b = 16'($urandom);
        p.corner_c = 16'($urandom);
        p.corner_d = 16'($urandom);
        // near-matching corners give small distances, else random
        if ($urandom_range(0, 1)) begin
            p.corner_a = p.match_phase + 16'($urandom_range(0, 800)) - 16'd400;
            p.corner_b = p.match_phase + 16'($urandom_range(0, 800)) - 16'd400;
            p.corner_c = p.match_phase + 16'($urandom_range(0, 800)) - 16'd400;
            p.corner_d = p.match_phase + 16'($urandom_range(0, 800)) - 16'd400;
        end
        p.frac_x = 16'($urandom);
        p.frac_y = 16'($urandom);
        p.last = ($urandom_range(1, 100) <= pct_last);
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_q.size() > 0 && !send_hold &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                pattern_t p;
                p = pending_q.pop_front();
                predict_cost(p);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {p.frac_y, p.frac_x, p.corner_d, p.corner_c,
                                 p.corner_b, p.corner_a, p.match_phase};
                s_axis_tlast <= p.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (cost_q.size() == 0) begin
                    report_mismatch("unexpected mean_cost", m_axis_tdata, 24'd0);
                end else begin
                    logic [17:0] want;
                    want = cost_q.pop_front();
                    if (m_axis_tdata[17:0] !== want)
                        report_mismatch("mean_cost", 24'(m_axis_tdata[17:0]), 24'(want));
                    if (m_axis_tdata[23:18] !== 6'd0)
                        report_mismatch("pad", 24'(m_axis_tdata[23:18]), 24'd0);
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYC) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_q.size() > 0 || s_axis_tvalid || cost_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [6:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        model_count = val;
    endtask

    task automatic run_phase(input int n, input int idle, input int stall, input int pct_last);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) pending_q.push_back(rand_pattern(pct_last));
        wait_idle();
    endtask

    initial begin
        pattern_t p;
        logic [15:0] edge_vals[6];
        send_hold = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        model_count = 1;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset count of 1, quadrant edges, offset extremes
        edge_vals = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF};
        for (int k = 0; k < 12; k++) begin
            p.match_phase = edge_vals[k % 6];
            p.corner_a = edge_vals[(k + 1) % 6];
            p.corner_b = edge_vals[(k + 2) % 6];
            p.corner_c = edge_vals[(k + 3) % 6];
            p.corner_d = edge_vals[(k + 4) % 6];
            p.frac_x = (k & 1) ? 16'hFFFF : 16'h0000;
            p.frac_y = (k & 2) ? 16'hFFFF : 16'h0000;
            p.last = (k % 3 != 0);
            pending_q.push_back(p);
        end
        // opposite vectors: largest distance, saturation of the mean
        p = '{16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 1'b0};
        pending_q.push_back(p);
        p.last = 1'b1;
        pending_q.push_back(p);
        wait_idle();

        // zero count divides as one
        write_count(7'd0);
        pending_q.push_back(p);
        // count of 127, the largest the 7-bit field holds
        wait_idle();
        write_count(7'd127);
        for (int k = 0; k < 6; k++) pending_q.push_back(p);
        p = '{16'hFFFF, 16'h0, 16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1};
        pending_q.push_back(p);
        wait_idle();

        write_count(7'd1);
        run_phase(300, 0, 0, 40);
        write_count(7'd64);
        run_phase(300, 88, 0, 10);
        write_count(7'd5);
        run_phase(300, 0, 88, 30);

        // sender holds mid-stream until every result is back, then resumes
        for (int k = 0; k < 20; k++) pending_q.push_back(rand_pattern(50));
        while (pending_q.size() > 10) @(posedge i_clk);
        send_hold = 1;
        while (s_axis_tvalid || cost_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        send_hold = 0;
        wait_idle();

        write_count(7'd3);
        run_phase(300, 17, 17, 35);
        write_count(7'd100);
        run_phase(50, 0, 0, 20);
        write_count(7'd2);
        run_phase(50, $urandom_range(0, 50), $urandom_range(0, 50), 50);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
